// ===== rtl/skf_pkg.sv =====
// Shared constants of the scalar Kalman filter: default widths, register
// indexes and register reset values. No dependencies.
`timescale 1ns / 1ps

package skf_pkg;

    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_COVARIANCE = 2'd3;

    localparam logic [63:0] RST_PROCESS_NOISE      = 64'd66;
    localparam logic [63:0] RST_MEASUREMENT_NOISE  = 64'd6554;
    localparam logic [63:0] RST_INITIAL_ESTIMATE   = 64'd0;
    localparam logic [63:0] RST_INITIAL_COVARIANCE = 64'd65536;

endpackage

// ===== rtl/scalar_kalman_filter_unit.sv =====
// Scalar Kalman filter top level: bit-serial gain divider and two
// shift-add multipliers around an estimate/covariance state.
// Depends on skf_pkg.
`timescale 1ns / 1ps

// Usage:
// - Slave stream (i_s_*): one measurement per item; tdata carries the signed
//   sample, tuser bit 0 is the restart flag that reloads the estimate and
//   covariance from the initial registers before this update.
// - Master stream (o_m_*): one result per item: filtered estimate, gain and
//   updated covariance.
// - Config channel (i_cfg_*): register index and data; always ready. Write
//   only while no item is in flight. Initial values act on restart or reset.
// - Each item runs from acceptance through the states PRED, PREP, DIV, MUL, RND
//   and UPD to a loaded output register; the divider runs GAIN_FRAC_BITS + 1
//   restoring steps, then both multipliers run GAIN_FRAC_BITS + 1 shift-add
//   steps. A new item is taken only once the state returns to idle after the
//   result is loaded.
// - Reset loads register defaults and sets the state from them; outputs idle.
// - A stalled receiver holds the result in the output register; the next item
//   is still accepted and computed, and waits in its last step until the
//   output register frees.
module scalar_kalman_filter_unit #(
    parameter int VALUE_WIDTH    = skf_pkg::VALUE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // sample
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // restart
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // filtered, gain, covariance_out
    output logic [((2*VALUE_WIDTH+GAIN_FRAC_BITS+1+7)/8)*8-1:0] o_m_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [skf_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]               i_cfg_data
);

    localparam int W       = VALUE_WIDTH;
    localparam int G       = GAIN_FRAC_BITS;
    localparam int OUT_RAW = 2*W + G + 1;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(G + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    localparam logic [W-1:0] RST_Q  = W'(skf_pkg::RST_PROCESS_NOISE);
    localparam logic [W-1:0] RST_R  = W'(skf_pkg::RST_MEASUREMENT_NOISE);
    localparam logic [W-1:0] RST_IE = W'(skf_pkg::RST_INITIAL_ESTIMATE);
    localparam logic [W-1:0] RST_IC = W'(skf_pkg::RST_INITIAL_COVARIANCE);

    localparam logic [G:0]       ONE   = {1'b1, {G{1'b0}}};
    localparam logic [W+G+1:0]   HALF  = {{(W+G+1){1'b0}}, 1'b1} << (G - 1);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(G);
    localparam logic signed [W+1:0] SMAX_E = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SMIN_E = {3'b111, {(W-1){1'b0}}};

    logic [2:0]       r_state;
    logic [W-1:0]     r_q, r_r, r_ie, r_ic;
    logic [W-1:0]     r_x, r_p, r_m;
    logic [W-1:0]     r_pp, r_mag;
    logic [W:0]       r_den;
    logic             r_neg, r_zero;
    logic [W+1:0]     r_rem;
    logic [G:0]       r_quo, r_k, r_mk, r_mc;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_hi1, r_hi2;
    logic [G:0]       r_lo1, r_lo2;
    logic [W:0]       r_corr;
    logic [W-1:0]     r_np;
    logic             r_out_valid;
    logic [W-1:0]     r_out_x, r_out_p;
    logic [G:0]       r_out_k;

    logic             s_accept, out_free;
    logic [W:0]       pp_sum, den_sum, diff;
    logic [W-1:0]     pp_sat, mag;
    logic [W+1:0]     div_t, div_sub;
    logic             div_ge;
    logic [G:0]       quo_next, k_final;
    logic [W:0]       s1, s2;
    logic [W+G+1:0]   rnd1, rnd2;
    logic signed [W+1:0] x_ext, c_ext, nx_w;
    logic [W-1:0]     nx;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign pp_sum  = {1'b0, r_p} + {1'b0, r_q};
    assign pp_sat  = pp_sum[W] ? {W{1'b1}} : pp_sum[W-1:0];
    assign den_sum = {1'b0, r_pp} + {1'b0, r_r};
    assign diff    = {r_m[W-1], r_m} - {r_x[W-1], r_x};
    assign mag     = diff[W] ? W'(~diff + 1'b1) : diff[W-1:0];

    assign div_t    = (r_cnt == '0) ? r_rem : {r_rem[W:0], 1'b0};
    assign div_sub  = div_t - {1'b0, r_den};
    assign div_ge   = (div_t >= {1'b0, r_den});
    assign quo_next = {r_quo[G-1:0], div_ge};
    assign k_final  = r_zero ? '0 : quo_next;

    assign s1 = {1'b0, r_hi1} + (r_mk[0] ? {1'b0, r_mag} : '0);
    assign s2 = {1'b0, r_hi2} + (r_mc[0] ? {1'b0, r_pp} : '0);

    assign rnd1 = {1'b0, r_hi1, r_lo1} + HALF;
    assign rnd2 = {1'b0, r_hi2, r_lo2} + HALF;

    assign x_ext = {r_x[W-1], r_x[W-1], r_x};
    assign c_ext = {1'b0, r_corr};
    assign nx_w  = r_neg ? (x_ext - c_ext) : (x_ext + c_ext);
    always_comb begin
        if (nx_w > SMAX_E) begin
            nx = SMAX_E[W-1:0];
        end else if (nx_w < SMIN_E) begin
            nx = SMIN_E[W-1:0];
        end else begin
            nx = nx_w[W-1:0];
        end
    end

    // Control, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_q         <= RST_Q;
            r_r         <= RST_R;
            r_ie        <= RST_IE;
            r_ic        <= RST_IC;
            r_x         <= RST_IE;
            r_p         <= RST_IC;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    skf_pkg::REG_PROCESS_NOISE:      r_q  <= i_cfg_data;
                    skf_pkg::REG_MEASUREMENT_NOISE:  r_r  <= i_cfg_data;
                    skf_pkg::REG_INITIAL_ESTIMATE:   r_ie <= i_cfg_data;
                    skf_pkg::REG_INITIAL_COVARIANCE: r_ic <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready && (r_state != S_UPD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        if (i_s_tuser) begin
                            r_x <= r_ie;
                            r_p <= r_ic;
                        end
                        r_state <= S_PRED;
                    end
                end
                S_PRED: r_state <= S_PREP;
                S_PREP: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == LAST) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == LAST) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: r_state <= S_UPD;
                S_UPD: begin
                    if (out_free) begin
                        r_x         <= nx;
                        r_p         <= r_np;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: serial divider, shift-add multipliers, rounding.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_m <= i_s_tdata[W-1:0];
                end
            end
            S_PRED: begin
                r_pp <= pp_sat;
            end
            S_PREP: begin
                r_den  <= den_sum;
                r_zero <= (den_sum == '0);
                r_neg  <= diff[W];
                r_mag  <= mag;
                r_rem  <= {2'b00, r_pp};
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_sub : div_t;
                r_quo <= quo_next;
                if (r_cnt == LAST) begin
                    r_k   <= k_final;
                    r_mk  <= k_final;
                    r_mc  <= ONE - k_final;
                    r_hi1 <= '0;
                    r_hi2 <= '0;
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                r_hi1 <= s1[W:1];
                r_lo1 <= {s1[0], r_lo1[G:1]};
                r_hi2 <= s2[W:1];
                r_lo2 <= {s2[0], r_lo2[G:1]};
                r_mk  <= {1'b0, r_mk[G:1]};
                r_mc  <= {1'b0, r_mc[G:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            S_RND: begin
                r_corr <= rnd1[W+G:G];
                r_np   <= rnd2[W+G-1:G];
            end
            S_UPD: begin
                if (out_free) begin
                    r_out_x <= nx;
                    r_out_k <= r_k;
                    r_out_p <= r_np;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_p, r_out_k, r_out_x});

`ifndef ASSERT_OFF
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_k <= ONE))
        else $error("gain above one");

    a_cov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_np <= r_pp))
        else $error("covariance grew past prediction");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_zero) |-> (r_k == '0))
        else $error("nonzero gain with zero denominator");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_PRED))
        else $error("accepted item did not start");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MUL) |-> (r_cnt <= LAST))
        else $error("step counter overran");
`endif

endmodule

// ===== bench/tb_scalar_kalman_filter_unit.sv =====
`timescale 1ns / 1ps
// Testbench for scalar_kalman_filter_unit: streams measurement items with random gaps and
// stalls, and checks each result against a fixed-point filter predictor in a scoreboard.
// Depends on skf_pkg and the filter RTL.

module tb_scalar_kalman_filter_unit;
    import skf_pkg::*;

    localparam int VW    = VALUE_WIDTH_DEF;
    localparam int GF    = GAIN_FRAC_BITS_DEF;
    localparam int IN_W  = ((VW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * VW + GF + 1 + 7) / 8) * 8;

    localparam logic [63:0] VMASK    = (64'd1 << VW) - 64'd1;
    localparam logic [63:0] GAIN_ONE = 64'd1 << GF;
    localparam logic [63:0] HALF     = GAIN_ONE >> 1;
    localparam longint      SMAX     = (longint'(1) << (VW - 1)) - 1;
    localparam longint      SMIN     = -SMAX - 1;

    localparam logic [VW-1:0] V_MAX = '1;
    localparam logic [VW-1:0] S_MAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] S_MIN = {1'b1, {(VW - 1){1'b0}}};

    localparam int QUIET_LIMIT     = 1000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 180;

    typedef struct packed {
        logic [VW-1:0] filtered;
        logic [GF:0]   gain;
        logic [VW-1:0] covariance;
    } filter_result_t;

    class filter_scoreboard;
        logic [VW-1:0]  q;
        logic [VW-1:0]  r;
        logic [VW-1:0]  x0;
        logic [VW-1:0]  p0;
        longint         est;
        logic [63:0]    cov;
        filter_result_t expected_results[$];
        int unsigned    mismatches;

        function new();
            q          = RST_PROCESS_NOISE[VW-1:0];
            r          = RST_MEASUREMENT_NOISE[VW-1:0];
            x0         = RST_INITIAL_ESTIMATE[VW-1:0];
            p0         = RST_INITIAL_COVARIANCE[VW-1:0];
            est        = to_signed(x0);
            cov        = 64'(p0);
            mismatches = 0;
        endfunction

        function longint to_signed(logic [VW-1:0] v);
            logic signed [VW-1:0] s;
            s = v;
            return s;
        endfunction

        function void note_register(logic [CFG_INDEX_WIDTH-1:0] index, logic [VW-1:0] value);
            case (index)
                REG_PROCESS_NOISE:      q  = value;
                REG_MEASUREMENT_NOISE:  r  = value;
                REG_INITIAL_ESTIMATE:   x0 = value;
                REG_INITIAL_COVARIANCE: p0 = value;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [VW-1:0] sample, logic restart);
            logic [63:0]    pp;
            logic [63:0]    den;
            logic [63:0]    rem;
            logic [63:0]    quo;
            logic [63:0]    mag;
            logic [63:0]    corr;
            logic [63:0]    np;
            longint         d;
            longint         nx;
            int             i;
            filter_result_t res;
            if (restart) begin
                est = to_signed(x0);
                cov = 64'(p0);
            end
            pp = cov + 64'(q);
            if (pp > VMASK) pp = VMASK;
            den = pp + 64'(r);
            quo = '0;
            rem = pp;
            if (den != 0) begin
                if (rem >= den) begin
                    rem = rem - den;
                    quo = 64'd1;
                end
                for (i = 0; i < GF; i++) begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= den) begin
                        rem    = rem - den;
                        quo[0] = 1'b1;
                    end
                end
            end
            if (quo > GAIN_ONE) quo = GAIN_ONE;
            d    = to_signed(sample) - est;
            mag  = (d < 0) ? 64'(-d) : 64'(d);
            corr = (mag * quo + HALF) >> GF;
            nx   = (d < 0) ? est - longint'(corr) : est + longint'(corr);
            if (nx > SMAX) nx = SMAX;
            if (nx < SMIN) nx = SMIN;
            np = ((GAIN_ONE - quo) * pp + HALF) >> GF;
            if (np > VMASK) np = VMASK;
            est = nx;
            cov = np;
            res.filtered   = VW'(nx);
            res.gain       = quo[GF:0];
            res.covariance = np[VW-1:0];
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            filter_result_t got;
            filter_result_t want;
            got.filtered   = data[VW-1:0];
            got.gain       = data[VW+GF:VW];
            got.covariance = data[2*VW+GF:VW+GF+1];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: filtered %h gain %h covariance %h",
                             got.filtered, got.gain, got.covariance);
                return;
            end
            want = expected_results.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected filtered %h gain %h covariance %h, got %h %h %h",
                             want.filtered, want.gain, want.covariance,
                             got.filtered, got.gain, got.covariance);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_s_tvalid  = 1'b0;
    logic                       o_s_tready;
    logic [IN_W-1:0]            i_s_tdata   = '0;
    logic                       i_s_tuser   = 1'b0;
    logic                       o_m_tvalid;
    logic                       i_m_tready  = 1'b0;
    logic [OUT_W-1:0]           o_m_tdata;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [VW-1:0]              i_cfg_data  = '0;

    filter_scoreboard sb;
    int unsigned      in_gap_max    = 4;
    int unsigned      out_stall_max = 4;
    int unsigned      ready_hold    = 0;
    int unsigned      quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    scalar_kalman_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always @(posedge i_clk) begin : result_side
        int unsigned stall;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
            stall = $urandom_range(out_stall_max);
            i_m_tready <= (stall == 0);
            ready_hold <= stall;
        end else if (ready_hold != 0) begin
            if (o_m_tvalid) begin
                ready_hold <= ready_hold - 1;
                i_m_tready <= (ready_hold == 1);
            end
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [VW-1:0] sample, input logic restart);
        int unsigned gap;
        gap = $urandom_range(in_gap_max);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'(sample);
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(sample, restart);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [VW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_register(index, value);
    endtask

    task automatic program_filter(input logic [VW-1:0] q, input logic [VW-1:0] r,
                                  input logic [VW-1:0] x0, input logic [VW-1:0] p0);
        drain();
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
        write_reg(REG_INITIAL_ESTIMATE, x0);
        write_reg(REG_INITIAL_COVARIANCE, p0);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_noise();
        case ($urandom_range(5))
            0:       return '0;
            1:       return V_MAX;
            2:       return $urandom;
            default: return $urandom_range(1 << 20, 1);
        endcase
    endfunction

    function automatic logic [VW-1:0] pick_start();
        case ($urandom_range(3))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return $urandom;
            default: return VW'(longint'($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [VW-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return VW'(sb.est + longint'($urandom_range(1 << 18)) - (1 << 17));
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults, sample extremes
        send_item('0, 1'b1);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MIN, 1'b1);
        send_item(V_MAX, 1'b0);
        send_item(32'h0001_0000, 1'b0);
        send_item(S_MAX, 1'b1);

        // zero denominator: gain stays zero, state holds
        program_filter('0, '0, 32'h1234_5678, '0);
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item('0, 1'b0);

        // unit gain with no measurement noise on the restart item, then zero covariance
        program_filter('0, '0, '0, 32'h0001_0000);
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(32'hFFFF_8000, 1'b0);

        // predicted covariance saturation
        program_filter(V_MAX, V_MAX, S_MIN, V_MAX);
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b0);
        program_filter(V_MAX, '0, S_MAX, '0);
        send_item(S_MIN, 1'b1);
        send_item(S_MAX, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            in_gap_max    = ($urandom_range(3) == 0) ? 0 : 4;
            out_stall_max = ($urandom_range(3) == 0) ? 0 : 4;
            program_filter(pick_noise(), pick_noise(), pick_start(), pick_noise());
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(pick_sample(), (n == 0) || ($urandom_range(19) == 0));
        end

        drain();
        repeat (2 * GF + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/skf_pkg.sv
rtl/scalar_kalman_filter_unit.sv
bench/tb_scalar_kalman_filter_unit.sv
